// ===== design/weno5_pkg.sv =====
// Shared widths, limits and helper functions for the WENO5 reconstruction pipeline.
// No dependencies; used by weno5_reconstruction.
package weno5_pkg;

  // Default fixed-point setup
  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_SHIFT_DEF = 20;

  // Sample and stencil arithmetic widths
  localparam int SMP_W  = 32;  // input and output samples
  localparam int P_W    = 36;  // signed work width for p, r
  localparam int MP_W   = 33;  // |p| bound
  localparam int MR_W   = 34;  // |r| bound
  localparam int N_W    = 37;  // candidate numerators (sixths)
  localparam int SQ_W   = 64;  // squared sample
  localparam int SUM_W  = 71;  // 13 p^2 + 3 r^2

  // Divide-by-three over radix-4 digits, four stages of eight digits
  localparam int D3_W     = 64;
  localparam int D3_DIG   = 8;
  localparam int D3_CHUNK = 2 * D3_DIG;
  localparam int D3_STG   = D3_W / D3_CHUNK;

  // Weight path
  localparam int WBITS  = 20;  // fraction bits of the Q1.20 ratio
  localparam int NORM_W = 32;  // normalized tk and m
  localparam int Q_W    = WBITS + 1;
  localparam int U_W    = WBITS + 1;
  localparam int W_W    = U_W + 2;  // up to 6 * 2^20
  localparam int WSUM_W = W_W + 1;
  localparam int PR_W   = 61;  // weight * numerator, and their sum
  localparam int DEN_W  = 26;  // 6 * weight sum
  localparam int X_W    = 59;  // |acc| + den/2
  localparam int FQ_W   = 36;  // final quotient

  localparam logic [Q_W-1:0]    Q_ONE   = Q_W'(1) << WBITS;
  localparam logic [DEN_W-1:0]  DEN_MIN = DEN_W'(6) << WBITS;
  localparam logic [FQ_W-1:0]   POS_LIM = FQ_W'(64'h0000_0000_7FFF_FFFF);
  localparam logic [FQ_W-1:0]   NEG_LIM = FQ_W'(64'h0000_0000_8000_0000);
  localparam logic [SMP_W-1:0]  SMP_MAX = 32'h7FFF_FFFF;
  localparam logic [SMP_W-1:0]  SMP_MIN = 32'h8000_0000;

  // Magnitude of a signed work value
  function automatic logic [P_W-1:0] mag(input logic signed [P_W-1:0] v);
    return v[P_W-1] ? P_W'(-v) : P_W'(v);
  endfunction

  // Eight radix-4 digits of a division by three; returns {remainder, quotient}
  function automatic logic [D3_CHUNK+1:0] div3_chunk(input logic [1:0] rem_in,
                                                    input logic [D3_CHUNK-1:0] chunk);
    logic [3:0] cur;
    logic [1:0] rem;
    logic [D3_CHUNK-1:0] q;
    rem = rem_in;
    q   = '0;
    for (int i = D3_DIG - 1; i >= 0; i--) begin
      cur = {rem, chunk[2*i +: 2]};
      if (cur >= 4'd9) begin
        q[2*i +: 2] = 2'd3;
        rem = 2'(cur - 4'd9);
      end else if (cur >= 4'd6) begin
        q[2*i +: 2] = 2'd2;
        rem = 2'(cur - 4'd6);
      end else if (cur >= 4'd3) begin
        q[2*i +: 2] = 2'd1;
        rem = 2'(cur - 4'd3);
      end else begin
        q[2*i +: 2] = 2'd0;
        rem = 2'(cur);
      end
    end
    return {rem, q};
  endfunction

endpackage

// ===== design/weno5_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data carried along.
// Uses no package items; instantiated by weno5_reconstruction.
module weno5_div #(
  parameter int X_W    = 52,
  parameter int D_W    = 32,
  parameter int Q_W    = 21,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [X_W-1:0]    x_i,
  input  logic [D_W-1:0]    d_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    q_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [Q_W-1:0]    vld_q;
  logic [D_W-1:0]    rem_q  [Q_W];
  logic [D_W-1:0]    d_q    [Q_W];
  logic [Q_W-1:0]    xq_q   [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  // Valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Q_W-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [D_W-1:0]    rem_in;
    logic [D_W-1:0]    d_in;
    logic [Q_W-1:0]    xq_in;
    logic [SIDE_W-1:0] side_in;
    logic [D_W:0]      trial;
    logic              ge;

    if (j == 0) begin : g_first
      // high part of the dividend is below the divisor
      assign rem_in  = D_W'(x_i >> Q_W);
      assign xq_in   = x_i[Q_W-1:0];
      assign d_in    = d_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign xq_in   = xq_q[j-1];
      assign d_in    = d_q[j-1];
      assign side_in = side_q[j-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign trial = {rem_in, xq_in[Q_W-1]};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? D_W'(trial - {1'b0, d_in}) : D_W'(trial);
        xq_q[j]   <= {xq_in[Q_W-2:0], ge};
        d_q[j]    <= d_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign q_o     = xq_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// ===== design/weno5_reconstruction.sv =====
// WENO5 reconstruction: 73 register stages, the last of them the output register.
// Throughput is one request per cycle; the pipeline advances unless a result waits
// in the output register while the last stage is also full and the sink stalls.
// The two long dividers (21 and 36 stages, one quotient bit each) set the depth.
// Reset clears valid bits only; data registers are not reset.
// Depends on weno5_pkg and weno5_div.
module weno5_reconstruction #(
  parameter int FRAC_BITS = weno5_pkg::FRAC_BITS_DEF,
  parameter int EPS_SHIFT = weno5_pkg::EPS_SHIFT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] sample_a_i,
  input  logic signed [31:0] sample_b_i,
  input  logic signed [31:0] sample_c_i,
  input  logic signed [31:0] sample_d_i,
  input  logic signed [31:0] sample_e_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] reconstructed_o
);

  localparam int SMP_W    = weno5_pkg::SMP_W;
  localparam int P_W      = weno5_pkg::P_W;
  localparam int MP_W     = weno5_pkg::MP_W;
  localparam int MR_W     = weno5_pkg::MR_W;
  localparam int N_W      = weno5_pkg::N_W;
  localparam int SQ_W     = weno5_pkg::SQ_W;
  localparam int SUM_W    = weno5_pkg::SUM_W;
  localparam int D3_W     = weno5_pkg::D3_W;
  localparam int D3_CHUNK = weno5_pkg::D3_CHUNK;
  localparam int D3_STG   = weno5_pkg::D3_STG;
  localparam int WBITS    = weno5_pkg::WBITS;
  localparam int NORM_W   = weno5_pkg::NORM_W;
  localparam int Q_W      = weno5_pkg::Q_W;
  localparam int U_W      = weno5_pkg::U_W;
  localparam int W_W      = weno5_pkg::W_W;
  localparam int WSUM_W   = weno5_pkg::WSUM_W;
  localparam int PR_W     = weno5_pkg::PR_W;
  localparam int DEN_W    = weno5_pkg::DEN_W;
  localparam int X_W      = weno5_pkg::X_W;
  localparam int FQ_W     = weno5_pkg::FQ_W;

  localparam int SHR    = FRAC_BITS + 2;
  localparam int T_W    = SUM_W - SHR;
  localparam int EPS_SH = FRAC_BITS + EPS_SHIFT;
  localparam int S_W    = $clog2(T_W - NORM_W + 1);
  localparam int FRONT  = 10;  // stages before the ratio dividers

  // Global advance
  logic adv;
  logic fin_valid;
  logic out_valid_q;

  assign adv        = !fin_valid || !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- front pipeline valid and numerator tracks ----------------
  logic [FRONT-1:0]        vld_q;
  logic signed [N_W-1:0]   nf_q [FRONT][3];

  // Stage A: stencil differences, candidate numerators, sample magnitudes
  logic signed [P_W-1:0] sx [5];
  logic signed [P_W-1:0] p_d [3];
  logic signed [P_W-1:0] r_d [3];
  logic signed [N_W-1:0] n_d [3];
  logic [MP_W-1:0]  a_mp_q [3];
  logic [MR_W-1:0]  a_mr_q [3];
  logic [SMP_W-1:0] a_mv_q [5];

  assign sx[0] = P_W'(sample_a_i);
  assign sx[1] = P_W'(sample_b_i);
  assign sx[2] = P_W'(sample_c_i);
  assign sx[3] = P_W'(sample_d_i);
  assign sx[4] = P_W'(sample_e_i);

  always_comb begin
    p_d[0] = sx[0] - (sx[1] <<< 1) + sx[2];
    r_d[0] = sx[0] - (sx[1] <<< 2) + (sx[2] <<< 1) + sx[2];
    p_d[1] = sx[1] - (sx[2] <<< 1) + sx[3];
    r_d[1] = sx[1] - sx[3];
    p_d[2] = sx[2] - (sx[3] <<< 1) + sx[4];
    r_d[2] = (sx[2] <<< 1) + sx[2] - (sx[3] <<< 2) + sx[4];
    n_d[0] = (N_W'(sx[0]) <<< 1) - (N_W'(sx[1]) <<< 3) + N_W'(sx[1])
           + (N_W'(sx[2]) <<< 3) + (N_W'(sx[2]) <<< 1) + N_W'(sx[2]);
    n_d[1] = -N_W'(sx[1]) + (N_W'(sx[2]) <<< 2) + N_W'(sx[2]) + (N_W'(sx[3]) <<< 1);
    n_d[2] = (N_W'(sx[2]) <<< 1) + (N_W'(sx[3]) <<< 2) + N_W'(sx[3]) - N_W'(sx[4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[FRONT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a_mp_q[k] <= MP_W'(weno5_pkg::mag(p_d[k]));
        a_mr_q[k] <= MR_W'(weno5_pkg::mag(r_d[k]));
        nf_q[0][k] <= n_d[k];
        for (int s = 1; s < FRONT; s++) begin
          nf_q[s][k] <= nf_q[s-1][k];
        end
      end
      for (int i = 0; i < 5; i++) begin
        a_mv_q[i] <= SMP_W'(weno5_pkg::mag(sx[i]));
      end
    end
  end

  // Stage B: squares
  logic [2*MP_W-1:0] b_pp_q [3];
  logic [2*MR_W-1:0] b_rr_q [3];
  logic [SQ_W-1:0]   b_sq_q [5];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        b_pp_q[k] <= (2*MP_W)'(a_mp_q[k]) * (2*MP_W)'(a_mp_q[k]);
        b_rr_q[k] <= (2*MR_W)'(a_mr_q[k]) * (2*MR_W)'(a_mr_q[k]);
      end
      for (int i = 0; i < 5; i++) begin
        b_sq_q[i] <= SQ_W'(a_mv_q[i]) * SQ_W'(a_mv_q[i]);
      end
    end
  end

  // Stage C: 13 p^2 + 3 r^2 scaled down, first level of the max tree
  logic [SUM_W-1:0] sum_d [3];
  logic [T_W-1:0]   c_sh_q [3];
  logic [SQ_W-1:0]  c_mx_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = (SUM_W'(b_pp_q[k]) << 3) + (SUM_W'(b_pp_q[k]) << 2) + SUM_W'(b_pp_q[k])
               + (SUM_W'(b_rr_q[k]) << 1) + SUM_W'(b_rr_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c_sh_q[k] <= T_W'(sum_d[k] >> SHR);
      end
      c_mx_q[0] <= (b_sq_q[0] > b_sq_q[1]) ? b_sq_q[0] : b_sq_q[1];
      c_mx_q[1] <= (b_sq_q[2] > b_sq_q[3]) ? b_sq_q[2] : b_sq_q[3];
      c_mx_q[2] <= b_sq_q[4];
    end
  end

  // Stages D..G: divide by three, sixteen bits per stage; eps alongside
  logic [D3_W-1:0] d3_val_q [D3_STG][3];
  logic [1:0]      d3_rem_q [D3_STG-1][3];

  for (genvar j = 0; j < D3_STG; j++) begin : g_d3
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [D3_W-1:0]     v_in;
      logic [D3_W-1:0]     v_out;
      logic [1:0]          r_in;
      logic [D3_CHUNK+1:0] res;

      if (j == 0) begin : g_first
        assign v_in = D3_W'(c_sh_q[k]);
        assign r_in = '0;
      end else begin : g_next
        assign v_in = d3_val_q[j-1][k];
        assign r_in = d3_rem_q[j-1][k];
      end

      assign res = weno5_pkg::div3_chunk(r_in, v_in[D3_W-1-D3_CHUNK*j -: D3_CHUNK]);

      always_comb begin
        v_out = v_in;
        v_out[D3_W-1-D3_CHUNK*j -: D3_CHUNK] = res[D3_CHUNK-1:0];
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          d3_val_q[j][k] <= v_out;
        end
      end

      if (j < D3_STG - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (adv) begin
            d3_rem_q[j][k] <= res[D3_CHUNK+1:D3_CHUNK];
          end
        end
      end
    end
  end

  logic [SQ_W-1:0] mx_q;
  logic [T_W-1:0]  eps_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (c_mx_q[0] >= c_mx_q[1] && c_mx_q[0] >= c_mx_q[2]) begin
        mx_q <= c_mx_q[0];
      end else if (c_mx_q[1] >= c_mx_q[2]) begin
        mx_q <= c_mx_q[1];
      end else begin
        mx_q <= c_mx_q[2];
      end
      eps_q[0] <= T_W'(mx_q >> EPS_SH) + T_W'(1);
      eps_q[1] <= eps_q[0];
      eps_q[2] <= eps_q[1];
    end
  end

  // Stage H: tk = Sk + eps
  logic [T_W-1:0] t_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        t_q[k] <= d3_val_q[D3_STG-1][k][T_W-1:0] + eps_q[2];
      end
    end
  end

  // Stage I: minimum and normalizing shift per lane
  logic [T_W-1:0] tmin_d;
  logic [S_W-1:0] s_d [3];
  logic [T_W-1:0] tmin_q;
  logic [T_W-1:0] ti_q [3];
  logic [S_W-1:0] s_q [3];

  always_comb begin
    tmin_d = t_q[0];
    if (t_q[1] < tmin_d) tmin_d = t_q[1];
    if (t_q[2] < tmin_d) tmin_d = t_q[2];
    for (int k = 0; k < 3; k++) begin
      s_d[k] = '0;
      for (int b = NORM_W; b < T_W; b++) begin
        if (t_q[k][b]) s_d[k] = S_W'(b - NORM_W + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tmin_q <= tmin_d;
      for (int k = 0; k < 3; k++) begin
        ti_q[k] <= t_q[k];
        s_q[k]  <= s_d[k];
      end
    end
  end

  // Stage J: apply shift to m and tk
  logic [NORM_W-1:0] mn_q [3];
  logic [NORM_W-1:0] tn_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        mn_q[k] <= NORM_W'(tmin_q >> s_q[k]);
        tn_q[k] <= NORM_W'(ti_q[k] >> s_q[k]);
      end
    end
  end

  // Ratio dividers: qk = m' * 2^20 / tk'
  logic                  r_valid [3];
  logic [Q_W-1:0]        r_q     [3];
  logic [N_W-1:0]        r_n     [3];

  for (genvar k = 0; k < 3; k++) begin : g_ratio
    weno5_div #(
      .X_W    (NORM_W + WBITS),
      .D_W    (NORM_W),
      .Q_W    (Q_W),
      .SIDE_W (N_W)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vld_q[FRONT-1]),
      .x_i     ({mn_q[k], WBITS'(0)}),
      .d_i     (tn_q[k]),
      .side_i  (nf_q[FRONT-1][k]),
      .valid_o (r_valid[k]),
      .q_o     (r_q[k]),
      .side_o  (r_n[k])
    );
  end

  // Stages K..O: squared ratios, weights, products, sums, rounding numerator
  logic                   k_v_q, l_v_q, m_v_q, n_v_q, o_v_q;
  logic [U_W-1:0]         k_u_q [3];
  logic signed [N_W-1:0]  k_n_q [3];
  logic [W_W-1:0]         l_w_q [3];
  logic signed [N_W-1:0]  l_n_q [3];
  logic signed [PR_W-1:0] m_prod_q [3];
  logic [WSUM_W-1:0]      m_wsum_q;
  logic signed [PR_W-1:0] acc_q;
  logic [DEN_W-1:0]       den_q;
  logic [PR_W-1:0]        amag_d;
  logic [X_W-1:0]         o_x_q;
  logic [DEN_W-1:0]       o_den_q;
  logic                   o_sign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_v_q <= 1'b0;
      l_v_q <= 1'b0;
      m_v_q <= 1'b0;
      n_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv) begin
      k_v_q <= r_valid[0];
      l_v_q <= k_v_q;
      m_v_q <= l_v_q;
      n_v_q <= m_v_q;
      o_v_q <= n_v_q;
    end
  end

  assign amag_d = acc_q[PR_W-1] ? PR_W'(-acc_q) : PR_W'(acc_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        k_u_q[k] <= U_W'(((2*Q_W)'(r_q[k]) * (2*Q_W)'(r_q[k])) >> WBITS);
        k_n_q[k] <= $signed(r_n[k]);
        l_n_q[k] <= k_n_q[k];
        m_prod_q[k] <= PR_W'($signed({1'b0, l_w_q[k]})) * PR_W'(l_n_q[k]);
      end
      // ideal weights 0.1, 0.6, 0.3 scaled by ten
      l_w_q[0] <= W_W'(k_u_q[0]);
      l_w_q[1] <= (W_W'(k_u_q[1]) << 2) + (W_W'(k_u_q[1]) << 1);
      l_w_q[2] <= (W_W'(k_u_q[2]) << 1) + W_W'(k_u_q[2]);
      m_wsum_q <= WSUM_W'(l_w_q[0]) + WSUM_W'(l_w_q[1]) + WSUM_W'(l_w_q[2]);
      acc_q    <= m_prod_q[0] + m_prod_q[1] + m_prod_q[2];
      den_q    <= DEN_W'({m_wsum_q, 2'b00}) + DEN_W'({m_wsum_q, 1'b0});
      // round half away from zero: (|acc| + den/2) / den
      o_x_q    <= X_W'(amag_d) + X_W'(den_q >> 1);
      o_den_q  <= den_q;
      o_sign_q <= acc_q[PR_W-1];
    end
  end

  // Final divider
  logic [FQ_W-1:0] fin_q;
  logic            fin_sign;

  weno5_div #(
    .X_W    (X_W),
    .D_W    (DEN_W),
    .Q_W    (FQ_W),
    .SIDE_W (1)
  ) u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (o_v_q),
    .x_i     (o_x_q),
    .d_i     (o_den_q),
    .side_i  (o_sign_q),
    .valid_o (fin_valid),
    .q_o     (fin_q),
    .side_o  (fin_sign)
  );

  // Sign and saturation into the output register
  logic [SMP_W-1:0] sat_d;
  logic [SMP_W-1:0] out_q;

  always_comb begin
    if (fin_sign) begin
      sat_d = (fin_q > weno5_pkg::NEG_LIM) ? weno5_pkg::SMP_MIN : SMP_W'(-fin_q);
    end else begin
      sat_d = (fin_q > weno5_pkg::POS_LIM) ? weno5_pkg::SMP_MAX : SMP_W'(fin_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= fin_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= sat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reconstructed_o = $signed(out_q);

  // ---------------- assertions ----------------
  // the three ratio lanes stay in lock step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid[0] == r_valid[1]) && (r_valid[0] == r_valid[2]))
    else $error("ratio divider lanes out of step");

  // normalized minimum never exceeds its tk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[FRONT-1] |-> (mn_q[0] <= tn_q[0]) && (mn_q[1] <= tn_q[1]) && (mn_q[2] <= tn_q[2]))
    else $error("normalized minimum above tk");

  // ratios are at most one and the minimum lane gives exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid[0] |-> (r_q[0] <= weno5_pkg::Q_ONE) && (r_q[1] <= weno5_pkg::Q_ONE)
                   && (r_q[2] <= weno5_pkg::Q_ONE)
                   && ((r_q[0] == weno5_pkg::Q_ONE) || (r_q[1] == weno5_pkg::Q_ONE)
                       || (r_q[2] == weno5_pkg::Q_ONE)))
    else $error("weight ratio out of range");

  // weight divisor is bounded below by the unit weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_v_q |-> (den_q >= weno5_pkg::DEN_MIN))
    else $error("weight divisor too small");

endmodule
